// ===== sv/gtsa_pkg.sv =====
// Shared types, constants and the digest mix function of the slot allocator.
`default_nettype none
package gtsa_pkg;

	localparam int unsigned SLOTS   = 64;
	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned CNT_W   = 7;
	localparam int unsigned GEN_W   = 64;
	localparam int unsigned OBJ_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [63:0] SLOT_MAGIC = 64'h5a69_4f62_6a53_6c74;
	localparam logic [63:0] TAIL_SALT  = 64'h5aa5_5aa5_5aa5_5aa5;
	localparam logic [63:0] MIX_ADD    = 64'h9e37_79b9_7f4a_7c15;

	// slot state codes folded into the header checksum
	localparam logic [63:0] HDR_ST_FREE = 64'd1;
	localparam logic [63:0] HDR_ST_BUSY = 64'd2;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_INDEX = 3'd1,
		ST_DBL_FREE  = 3'd2,
		ST_NO_SLOT   = 3'd3,
		ST_GEN_EXH   = 3'd4
	} status_t;

	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COOKIE     = 2'd0,
		CFG_SLOT_COUNT = 2'd1,
		CFG_OBJ_SIZE   = 2'd2
	} cfg_reg_t;

	// one chaining step: h ^ (v + K + (h << 6) + (h >> 2)), modulo 2^64
	function automatic logic [63:0] mix(input logic [63:0] h, input logic [63:0] v);
		mix = h ^ (v + MIX_ADD + (h << 6) + (h >> 2));
	endfunction

endpackage
`default_nettype wire

// ===== sv/gtsa_req_if.sv =====
// Request channel interface: valid/ready with request type and slot index.
`default_nettype none
interface gtsa_req_if;
	import gtsa_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [SLOT_W-1:0] slot_index;

	modport source (output valid, output req_type, output slot_index, input ready);
	modport sink   (input valid, input req_type, input slot_index, output ready);
endinterface
`default_nettype wire

// ===== sv/gtsa_rsp_if.sv =====
// Result channel interface: valid/ready with status, slot, generation and digests.
`default_nettype none
interface gtsa_rsp_if;
	import gtsa_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [SLOT_W-1:0] granted_slot;
	logic [GEN_W-1:0]  slot_generation;
	logic [63:0]       header_checksum;
	logic [63:0]       tail_canary;
	logic [CNT_W-1:0]  active_count;

	modport source (output valid, output status, output granted_slot,
		output slot_generation, output header_checksum, output tail_canary,
		output active_count, input ready);
	modport sink (input valid, input status, input granted_slot,
		input slot_generation, input header_checksum, input tail_canary,
		input active_count, output ready);
endinterface
`default_nettype wire

// ===== sv/generation_tagged_slot_allocator.sv =====
// Top level of the generation-tagged fixed-slot allocator.
// The allocator takes one request item per cycle unless the output stalls, and
// returns one result item per request from the last digest stage. The slot
// decision (lowest free slot via a priority encode over the busy bitmap, range,
// double-free and generation checks) and the state update happen in the cycle
// the request is accepted, so back-to-back requests always see up-to-date busy
// bits. The header checksum and the tail canary are chains of 64-bit mix steps;
// one mix step per stage gives three digest stages after the decision stage,
// and that chain sets the latency. A result held at the output stalls the stages
// behind it; free stages still accept items. The user must write configuration
// through the cfg port only while no request is in flight; the block does not
// enforce it. The cookie-magic mix is precomputed the cycle after a cookie write.
`default_nettype none
module generation_tagged_slot_allocator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gtsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]                   cfg_wdata,
	gtsa_req_if.sink                           req,
	gtsa_rsp_if.source                         rsp
);
	import gtsa_pkg::*;

	// configuration
	logic [63:0]      cookie_q;
	logic [CNT_W-1:0] slot_count_q;
	logic [OBJ_W-1:0] obj_size_q;
	logic [63:0]      hdr_seed_q;

	// allocator state
	logic [SLOTS-1:0] busy_q;
	logic [GEN_W-1:0] cur_gen_q;
	logic [CNT_W-1:0] busy_total_q;

	// decision logic
	logic [CNT_W-1:0]  eff_n;
	logic [SLOTS-1:0]  free_vec;
	logic              found;
	logic [SLOT_W-1:0] low_idx;
	logic              idx_in_range;
	logic              gen_max;
	status_t           dec_status;
	logic              dec_ok;
	logic              is_alloc;
	logic [SLOT_W-1:0] tgt_slot;
	logic              accept;

	// pipeline control
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic adv1, adv2, adv3, adv4;

	// pipeline payload
	status_t           status_s1, status_s2, status_s3;
	logic [2:0]        status_s4;
	logic [SLOT_W-1:0] slot_s1, slot_s2, slot_s3, slot_s4;
	logic [GEN_W-1:0]  gen_s1, gen_s2, gen_s3, gen_s4;
	logic              ok_s1, ok_s2, ok_s3;
	logic              alloc_s1, alloc_s2, alloc_s3;
	logic [CNT_W-1:0]  act_s1, act_s2, act_s3, act_s4;
	logic [63:0]       hdr_s2, hdr_s3, hdr_s4;
	logic [63:0]       tail_s2, tail_s3, tail_s4;

	// effective slot count: clamp to what is built
	assign eff_n = (slot_count_q > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : slot_count_q;

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_vec[i] = ~busy_q[i] & (CNT_W'(i) < eff_n);
		end
	end

	assign found = |free_vec;

	// priority encode: lowest free slot wins
	always_comb begin
		low_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				low_idx = SLOT_W'(i);
			end
		end
	end

	assign is_alloc     = (req.req_type == REQ_ALLOC);
	assign idx_in_range = ({1'b0, req.slot_index} < eff_n);
	assign gen_max      = &cur_gen_q;

	always_comb begin
		if (is_alloc) begin
			if (!found) begin
				dec_status = ST_NO_SLOT;
			end else if (gen_max) begin
				dec_status = ST_GEN_EXH;
			end else begin
				dec_status = ST_OK;
			end
		end else begin
			if (!idx_in_range) begin
				dec_status = ST_BAD_INDEX;
			end else if (!busy_q[req.slot_index]) begin
				dec_status = ST_DBL_FREE;
			end else if (gen_max) begin
				dec_status = ST_GEN_EXH;
			end else begin
				dec_status = ST_OK;
			end
		end
	end

	assign dec_ok   = (dec_status == ST_OK);
	assign tgt_slot = is_alloc ? low_idx : req.slot_index;

	// ready chain: a stage moves when it is empty or its successor moves
	assign adv4 = !v4_s4 || rsp.ready;
	assign adv3 = !v3_s3 || adv4;
	assign adv2 = !v2_s2 || adv3;
	assign adv1 = !v1_s1 || adv2;
	assign req.ready = adv1;
	assign accept = req.valid && adv1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cookie_q     <= '0;
			slot_count_q <= CNT_W'(64);
			obj_size_q   <= OBJ_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COOKIE:     cookie_q     <= cfg_wdata;
				CFG_SLOT_COUNT: slot_count_q <= cfg_wdata[CNT_W-1:0];
				CFG_OBJ_SIZE:   obj_size_q   <= cfg_wdata[OBJ_W-1:0];
				default: ;
			endcase
		end
	end

	// first header mix depends on the cookie only
	always_ff @(posedge clk) begin
		hdr_seed_q <= mix(cookie_q, SLOT_MAGIC);
	end

	// allocator state and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= '0;
			cur_gen_q    <= GEN_W'(1);
			busy_total_q <= '0;
			v1_s1        <= 1'b0;
			v2_s2        <= 1'b0;
			v3_s3        <= 1'b0;
			v4_s4        <= 1'b0;
		end else begin
			if (accept && dec_ok) begin
				busy_q[tgt_slot] <= is_alloc;
				cur_gen_q        <= cur_gen_q + GEN_W'(1);
				busy_total_q     <= is_alloc ? busy_total_q + CNT_W'(1)
					: busy_total_q - CNT_W'(1);
			end
			if (adv1) v1_s1 <= req.valid;
			if (adv2) v2_s2 <= v1_s1;
			if (adv3) v3_s3 <= v2_s2;
			if (adv4) v4_s4 <= v3_s3;
		end
	end

	// payload pipeline: decision, then one mix step per stage
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= dec_status;
			ok_s1     <= dec_ok;
			alloc_s1  <= dec_ok && is_alloc;
			slot_s1   <= dec_ok ? tgt_slot : '0;
			gen_s1    <= dec_ok ? cur_gen_q + GEN_W'(1) : '0;
			act_s1    <= dec_ok ? (is_alloc ? busy_total_q + CNT_W'(1)
				: busy_total_q - CNT_W'(1)) : busy_total_q;
		end
		if (adv2) begin
			status_s2 <= status_s1;
			ok_s2     <= ok_s1;
			alloc_s2  <= alloc_s1;
			slot_s2   <= slot_s1;
			gen_s2    <= gen_s1;
			act_s2    <= act_s1;
			hdr_s2    <= mix(hdr_seed_q, gen_s1);
			tail_s2   <= mix(cookie_q ^ TAIL_SALT, gen_s1);
		end
		if (adv3) begin
			status_s3 <= status_s2;
			ok_s3     <= ok_s2;
			alloc_s3  <= alloc_s2;
			slot_s3   <= slot_s2;
			gen_s3    <= gen_s2;
			act_s3    <= act_s2;
			hdr_s3    <= mix(hdr_s2, alloc_s2 ? HDR_ST_BUSY : HDR_ST_FREE);
			tail_s3   <= mix(tail_s2, {{(64-SLOT_W){1'b0}}, slot_s2});
		end
		if (adv4) begin
			status_s4 <= status_s3;
			slot_s4   <= slot_s3;
			gen_s4    <= gen_s3;
			act_s4    <= act_s3;
			// drop the digests on error; the canary only on a granted allocate
			hdr_s4    <= ok_s3 ? mix(hdr_s3, {{(64-SLOT_W){1'b0}}, slot_s3}) : '0;
			tail_s4   <= alloc_s3 ? mix(tail_s3, {{(64-OBJ_W){1'b0}}, obj_size_q}) : '0;
		end
	end

	assign rsp.valid           = v4_s4;
	assign rsp.status          = status_s4;
	assign rsp.granted_slot    = slot_s4;
	assign rsp.slot_generation = gen_s4;
	assign rsp.header_checksum = hdr_s4;
	assign rsp.tail_canary     = tail_s4;
	assign rsp.active_count    = act_s4;

	// busy counter tracks the bitmap
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		busy_total_q == CNT_W'($countones(busy_q)))
		else $error("busy count differs from busy bitmap");

	// a granted request advances the generation by exactly one
	a_gen_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dec_ok) |=> cur_gen_q == $past(cur_gen_q) + GEN_W'(1))
		else $error("generation did not advance on a granted request");

	// a rejected request leaves the state alone
	a_err_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !dec_ok) |=> $stable(busy_q) && $stable(cur_gen_q))
		else $error("state changed on a rejected request");

	// error results carry no generation and no digests
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v4_s4 && status_s4 != ST_OK) |->
			(gen_s4 == '0 && hdr_s4 == '0 && tail_s4 == '0 && slot_s4 == '0))
		else $error("error result carries payload");

	// an allocate never grants a busy slot
	a_alloc_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dec_ok && is_alloc) |-> !busy_q[low_idx])
		else $error("allocate granted a busy slot");

endmodule
`default_nettype wire

// ===== verif/tb_generation_tagged_slot_allocator.sv =====
// Self-checking testbench for the generation-tagged slot allocator.
module tb_generation_tagged_slot_allocator;
	timeunit 1ns;
	timeprecision 1ps;

	import gtsa_pkg::*;

	// Depth of the block's result pipeline; the waits allow a little slack on top.
	localparam int unsigned PIPE_LAT    = 4;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASES      = 8;
	localparam int unsigned PHASE_ITEMS = 135;

	// One result item as the block reports it.
	typedef struct packed {
		logic [2:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [GEN_W-1:0]  gen;
		logic [63:0]       chk;
		logic [63:0]       canary;
		logic [CNT_W-1:0]  active;
	} grant_t;

	// One line of the directed script: either a register write or a request item.
	// Request lines carry the status, slot, generation and count read off by hand;
	// the two digests always come from the predictor.
	typedef struct {
		bit                is_cfg;
		cfg_reg_t          target;
		logic [63:0]       value;
		req_t              kind;
		logic [SLOT_W-1:0] idx;
		bit                typed;
		grant_t            want;
	} script_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_wdata;

	gtsa_req_if req ();
	gtsa_rsp_if rsp ();

	generation_tagged_slot_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// Shadow copy of the allocator: registers and slot state as the block should hold them.
	logic [63:0]      sh_cookie     = '0;
	logic [CNT_W-1:0] sh_slot_count = 7'd64;
	logic [OBJ_W-1:0] sh_obj_size   = 16'd64;
	bit               sh_busy [SLOTS] = '{default: 1'b0};
	logic [GEN_W-1:0] sh_gen        = 64'd1;
	logic [CNT_W-1:0] sh_active     = '0;

	grant_t      pending_grants [$];
	script_row_t script [$];

	int unsigned gap_pct     = 0;
	int unsigned stall_pct   = 0;
	int unsigned stall_left  = 0;
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;

	// Free-running clock, 20 ns period.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort the run if the pipeline never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// One add-shift-xor chaining step of the digests, modulo 2^64.
	function automatic logic [63:0] stir(logic [63:0] h, logic [63:0] v);
		return h ^ (v + MIX_ADD + (h << 6) + (h >> 2));
	endfunction

	function automatic logic [63:0] header_digest(logic [63:0] gen, logic [63:0] st,
			logic [63:0] idx);
		return stir(stir(stir(stir(sh_cookie, SLOT_MAGIC), gen), st), idx);
	endfunction

	// Slots in play: slot_count clipped to the built size and to 64.
	function automatic int unsigned live_span();
		int unsigned n;
		n = sh_slot_count;
		if (n > SLOTS)
			n = SLOTS;
		if (n > 64)
			n = 64;
		return n;
	endfunction

	// Work out the result of one request and advance the shadow state.
	// Any error leaves the state untouched.
	function automatic grant_t predict_grant(req_t kind, logic [SLOT_W-1:0] idx);
		grant_t      g;
		int unsigned n;
		int          pick;
		int          i;
		g    = '0;
		n    = live_span();
		pick = -1;
		if (kind == REQ_ALLOC) begin
			// lowest free slot below the span wins; a full span is checked first
			for (i = 0; i < int'(n); i++)
				if (!sh_busy[i] && pick < 0)
					pick = i;
			if (pick < 0) begin
				g.status = ST_NO_SLOT;
			end else if (sh_gen == '1) begin
				g.status = ST_GEN_EXH;
			end else begin
				sh_gen        = sh_gen + 1;
				sh_busy[pick] = 1'b1;
				sh_active     = sh_active + 7'd1;
				g.status      = ST_OK;
				g.slot        = pick[SLOT_W-1:0];
				g.gen         = sh_gen;
				g.chk         = header_digest(sh_gen, HDR_ST_BUSY, 64'(pick));
				g.canary      = stir(stir(stir(sh_cookie ^ TAIL_SALT, sh_gen), 64'(pick)),
					64'(sh_obj_size));
			end
		end else begin
			// range first, then double free, then generation
			if (idx >= n) begin
				g.status = ST_BAD_INDEX;
			end else if (!sh_busy[idx]) begin
				g.status = ST_DBL_FREE;
			end else if (sh_gen == '1) begin
				g.status = ST_GEN_EXH;
			end else begin
				sh_gen       = sh_gen + 1;
				sh_busy[idx] = 1'b0;
				sh_active    = sh_active - 7'd1;
				g.status     = ST_OK;
				g.slot       = idx;
				g.gen        = sh_gen;
				g.chk        = header_digest(sh_gen, HDR_ST_FREE, 64'(idx));
			end
		end
		g.active = sh_active;
		return g;
	endfunction

	// Present one request item, hold it until accepted, then queue its prediction.
	// Typed lines replace the predicted status, slot, generation and count.
	task automatic send_item(req_t kind, logic [SLOT_W-1:0] idx, bit typed, grant_t want);
		grant_t g;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.req_type   <= kind;
		req.slot_index <= idx;
		do
			@(posedge clk);
		while (!req.ready);
		g = predict_grant(kind, idx);
		if (typed) begin
			g.status = want.status;
			g.slot   = want.slot;
			g.gen    = want.gen;
			g.active = want.active;
		end
		pending_grants.push_back(g);
	endtask

	// Write one register with the pipeline empty, then give the cookie
	// precompute time to settle before the next item.
	task automatic write_reg(cfg_reg_t target, logic [63:0] value);
		req.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= target;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (target)
			CFG_COOKIE:     sh_cookie     = value;
			CFG_SLOT_COUNT: sh_slot_count = value[CNT_W-1:0];
			CFG_OBJ_SIZE:   sh_obj_size   = value[OBJ_W-1:0];
			default: ;
		endcase
		repeat (2) @(posedge clk);
	endtask

	task automatic put_req(req_t kind, logic [SLOT_W-1:0] idx, bit typed, status_t st,
			logic [SLOT_W-1:0] slot, logic [GEN_W-1:0] gen, logic [CNT_W-1:0] act);
		script_row_t r;
		r             = '{is_cfg: 1'b0, target: CFG_COOKIE, value: '0, kind: kind,
			idx: idx, typed: typed, want: '0};
		r.want.status = st;
		r.want.slot   = slot;
		r.want.gen    = gen;
		r.want.active = act;
		script.push_back(r);
	endtask

	task automatic put_cfg(cfg_reg_t target, logic [63:0] value);
		script_row_t r;
		r = '{is_cfg: 1'b1, target: target, value: value, kind: REQ_ALLOC,
			idx: '0, typed: 1'b0, want: '0};
		script.push_back(r);
	endtask

	// Result side backpressure: drop ready in random bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			rsp.ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			rsp.ready <= 1'b0;
			stall_left = $urandom_range(2);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Compare every accepted result item against the oldest prediction.
	always @(posedge clk) begin : check_results
		grant_t seen;
		grant_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			seen.status = rsp.status;
			seen.slot   = rsp.granted_slot;
			seen.gen    = rsp.slot_generation;
			seen.chk    = rsp.header_checksum;
			seen.canary = rsp.tail_canary;
			seen.active = rsp.active_count;
			if (pending_grants.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: result item with nothing outstanding: st=%0d slot=%0d",
						$realtime, seen.status, seen.slot);
				mismatches = mismatches + 1;
			end else begin
				want = pending_grants.pop_front();
				if (seen !== want) begin
					if (mismatches < 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  exp st=%0d slot=%0d gen=%h chk=%h tail=%h act=%0d",
							want.status, want.slot, want.gen, want.chk, want.canary,
							want.active);
						$display("  got st=%0d slot=%0d gen=%h chk=%h tail=%h act=%0d",
							seen.status, seen.slot, seen.gen, seen.chk, seen.canary,
							seen.active);
					end
					mismatches = mismatches + 1;
				end
			end
		end
	end

	initial begin
		int unsigned       ph;
		int unsigned       n;
		int unsigned       alloc_pct;
		int unsigned       i;
		req_t              kind;
		logic [SLOT_W-1:0] idx;
		logic [CNT_W-1:0]  sc;
		logic [63:0]       cookie;
		logic [OBJ_W-1:0]  osz;
		int unsigned       held [$];

		// Drive every input to a known value from time zero.
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_COOKIE;
		cfg_wdata      = '0;
		req.valid      = 1'b0;
		req.req_type   = REQ_ALLOC;
		req.slot_index = '0;
		rsp.ready      = 1'b1;

		// Directed script, starting from reset values: cookie 0, 64 slots, size 64.
		put_req(REQ_FREE,  6'd0,  1, ST_DBL_FREE,  6'd0, 64'd0,  7'd0); // free on empty
		put_req(REQ_ALLOC, 6'd63, 1, ST_OK,        6'd0, 64'd2,  7'd1); // index ignored
		put_req(REQ_ALLOC, 6'd0,  1, ST_OK,        6'd1, 64'd3,  7'd2);
		put_req(REQ_FREE,  6'd63, 1, ST_DBL_FREE,  6'd0, 64'd0,  7'd2); // top slot free
		put_req(REQ_FREE,  6'd0,  1, ST_OK,        6'd0, 64'd4,  7'd1);
		put_req(REQ_FREE,  6'd0,  1, ST_DBL_FREE,  6'd0, 64'd0,  7'd1);
		put_req(REQ_ALLOC, 6'd0,  1, ST_OK,        6'd0, 64'd5,  7'd2); // reuse lowest
		put_cfg(CFG_SLOT_COUNT, 64'd2);
		put_req(REQ_ALLOC, 6'd0,  1, ST_NO_SLOT,   6'd0, 64'd0,  7'd2); // span full
		put_req(REQ_FREE,  6'd2,  1, ST_BAD_INDEX, 6'd0, 64'd0,  7'd2); // just past span
		put_req(REQ_FREE,  6'd63, 1, ST_BAD_INDEX, 6'd0, 64'd0,  7'd2);
		put_cfg(CFG_SLOT_COUNT, 64'd0);                                   // empty span
		put_req(REQ_ALLOC, 6'd0,  1, ST_NO_SLOT,   6'd0, 64'd0,  7'd2);
		put_req(REQ_FREE,  6'd0,  1, ST_BAD_INDEX, 6'd0, 64'd0,  7'd2);
		put_cfg(CFG_SLOT_COUNT, 64'd127);                                 // clips to 64
		put_req(REQ_ALLOC, 6'd0,  1, ST_OK,        6'd2, 64'd6,  7'd3);
		put_cfg(CFG_COOKIE, '1);
		put_cfg(CFG_OBJ_SIZE, 64'hffff);
		put_req(REQ_ALLOC, 6'd0,  1, ST_OK,        6'd3, 64'd7,  7'd4);
		put_cfg(CFG_OBJ_SIZE, 64'd1);
		put_cfg(CFG_COOKIE, 64'h0123_4567_89ab_cdef);
		put_req(REQ_FREE,  6'd1,  1, ST_OK,        6'd1, 64'd8,  7'd3);
		put_cfg(CFG_SLOT_COUNT, 64'd1);                                   // strand slots 2, 3
		put_req(REQ_FREE,  6'd3,  1, ST_BAD_INDEX, 6'd0, 64'd0,  7'd3);
		put_req(REQ_ALLOC, 6'd0,  1, ST_NO_SLOT,   6'd0, 64'd0,  7'd3);
		put_req(REQ_FREE,  6'd0,  1, ST_OK,        6'd0, 64'd9,  7'd2);
		put_req(REQ_ALLOC, 6'd0,  1, ST_OK,        6'd0, 64'd10, 7'd3);
		put_cfg(CFG_SLOT_COUNT, 64'd64);
		put_req(REQ_ALLOC, 6'd42, 0, ST_OK,        6'd0, 64'd0,  7'd0);
		put_req(REQ_FREE,  6'd3,  0, ST_OK,        6'd0, 64'd0,  7'd0);

		// Hold reset, then release it at a clock edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the script with moderate idling on both sides.
		gap_pct   = 25;
		stall_pct = 25;
		foreach (script[r]) begin
			if (script[r].is_cfg)
				write_reg(script[r].target, script[r].value);
			else
				send_item(script[r].kind, script[r].idx, script[r].typed, script[r].want);
		end

		// Random phases: reprogram every register, then run a mix of allocates and
		// frees. Frees mostly name a slot that is held, so the bitmap fills and drains.
		for (ph = 0; ph < PHASES; ph++) begin
			cookie    = {$urandom, $urandom};
			osz       = OBJ_W'($urandom_range(0, 65535));
			alloc_pct = $urandom_range(30, 75);
			case (ph)
				0: begin
					sc        = 7'd64;
					cookie    = '1;
					osz       = 16'hffff;
					alloc_pct = 80;                 // drive the span to full
				end
				1: begin
					sc     = 7'd1;
					cookie = '0;
					osz    = 16'd1;
				end
				2: sc = CNT_W'($urandom_range(2, 8));
				3: sc = 7'd127;
				4: sc = CNT_W'($urandom_range(9, 63));
				5: sc = CNT_W'($urandom_range(0, 127));
				default: sc = 7'd64;
			endcase
			write_reg(CFG_COOKIE, cookie);
			write_reg(CFG_SLOT_COUNT, 64'(sc));
			write_reg(CFG_OBJ_SIZE, 64'(osz));

			// Alternate idling patterns; the last phase runs flat out.
			if (ph == PHASES - 1) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else begin
				gap_pct   = (ph % 3 == 0) ? 0 : 30;
				stall_pct = (ph % 3 == 1) ? 0 : 30;
			end

			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(99) < alloc_pct) begin
					kind = REQ_ALLOC;
					idx  = SLOT_W'($urandom_range(63));
				end else begin
					kind = REQ_FREE;
					held.delete();
					for (i = 0; i < live_span(); i++)
						if (sh_busy[i])
							held.push_back(i);
					if (held.size() != 0 && $urandom_range(99) < 80)
						idx = SLOT_W'(held[$urandom_range(held.size() - 1)]);
					else
						idx = SLOT_W'($urandom_range(63));
				end
				send_item(kind, idx, 1'b0, '0);
			end
		end

		// Drain: drop valid, wait for every prediction to be matched, then linger.
		req.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
